/* design/hse_pkg.sv */
package hse_pkg;

   localparam int unsigned NUM_BUCKETS_DEF = 128;
   localparam int unsigned WAYS_DEF        = 4;
   localparam int unsigned KEY_W           = 32;
   localparam int unsigned COUNT_W         = 10;

   // Request codes. The unused code is served as a membership query.
   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_QUERY  = 2'd1;
   localparam logic [1:0] REQ_REMOVE = 2'd2;

   // Result status codes.
   localparam logic [2:0] ST_INSERTED  = 3'd0;
   localparam logic [2:0] ST_PRESENT   = 3'd1;
   localparam logic [2:0] ST_FOUND     = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_REMOVED   = 3'd4;
   localparam logic [2:0] ST_FULL      = 3'd5;

   typedef struct packed {
      logic [1:0]              req_type;
      logic signed [KEY_W-1:0] key;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [COUNT_W-1:0] element_count;
   } rsp_payload_type;

   typedef struct packed {
      logic ready;
      logic clearing;
   } tbl_status_type;

endpackage

/* design/hse_hash.sv */
module hse_hash import hse_pkg::*; #(
   parameter int unsigned NUM_BUCKETS = NUM_BUCKETS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  req_payload_type                in_req,
   input  logic                           advance,
   output logic                           out_valid,
   output req_payload_type                out_req,
   output logic [$clog2(NUM_BUCKETS)-1:0] out_bucket
);

   localparam int unsigned BKT_W = $clog2(NUM_BUCKETS);
   localparam int unsigned REM_W = BKT_W + 1;
   localparam logic [2*KEY_W-1:0] RECIP_WIDE = (64'd1 << KEY_W) / NUM_BUCKETS;
   localparam logic [KEY_W-1:0]   RECIP      = RECIP_WIDE[KEY_W-1:0];
   localparam logic [REM_W-1:0]   NB         = REM_W'(NUM_BUCKETS);

   logic                  s1_valid_ff;
   req_payload_type       s1_req_ff;
   logic [2*KEY_W-1:0]    s1_prod;

   logic                  s2_valid_ff;
   req_payload_type       s2_req_ff;
   logic [REM_W-1:0]      s2_q_ff;
   logic [REM_W-1:0]      s2_q_in;
   logic [2*REM_W-1:0]    s2_qn;
   logic [REM_W-1:0]      s2_rem;

   logic                  s3_valid_ff;
   req_payload_type       s3_req_ff;
   logic [REM_W-1:0]      s3_rem_ff;
   logic [REM_W-1:0]      s3_rem_fix;

   // The reciprocal estimate of the quotient is exact or one short, so the
   // remainder estimate lies below twice the bucket count and only its low
   // bits are needed.
   assign s1_prod = {{KEY_W{1'b0}}, s1_req_ff.key} * {{KEY_W{1'b0}}, RECIP};
   assign s2_q_in = s1_prod[KEY_W +: REM_W];

   assign s2_qn  = {{REM_W{1'b0}}, s2_q_ff} * {{REM_W{1'b0}}, NB};
   assign s2_rem = s2_req_ff.key[REM_W-1:0] - s2_qn[REM_W-1:0];

   assign s3_rem_fix = (s3_rem_ff >= NB) ? (s3_rem_ff - NB) : s3_rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_req_ff <= in_req;
         s2_req_ff <= s1_req_ff;
         s2_q_ff   <= s2_q_in;
         s3_req_ff <= s2_req_ff;
         s3_rem_ff <= s2_rem;
      end
   end

   assign out_valid  = s3_valid_ff;
   assign out_req    = s3_req_ff;
   assign out_bucket = s3_rem_fix[BKT_W-1:0];

endmodule

/* design/hse_table.sv */
module hse_table import hse_pkg::*; #(
   parameter int unsigned NUM_BUCKETS     = NUM_BUCKETS_DEF,
   parameter int unsigned WAYS_PER_BUCKET = WAYS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           take,
   input  req_payload_type                take_req,
   input  logic [$clog2(NUM_BUCKETS)-1:0] take_bucket,
   output tbl_status_type                 status,
   output logic                           res_valid,
   input  logic                           res_ready,
   output rsp_payload_type                res_data
);

   localparam int unsigned BKT_W = $clog2(NUM_BUCKETS);
   localparam int unsigned WAYS  = WAYS_PER_BUCKET;
   localparam int unsigned ROW_W = WAYS * (KEY_W + 1);

   // One row per bucket: the keys of all ways above their occupied bits.
   logic [ROW_W-1:0]            row_mem_ff [NUM_BUCKETS];
   logic [ROW_W-1:0]            rd_row_ff;

   logic                        clr_active_ff;
   logic [BKT_W-1:0]            clr_idx_ff;

   logic                        lk_valid_ff;
   req_payload_type             lk_req_ff;
   logic [BKT_W-1:0]            lk_bucket_ff;

   logic [COUNT_W-1:0]          count_ff;
   logic [COUNT_W-1:0]          count_in;

   logic [WAYS-1:0]             rd_valid;
   logic [WAYS-1:0][KEY_W-1:0]  rd_keys;
   logic [WAYS-1:0]             hit;
   logic [WAYS-1:0]             hit_oh;
   logic [WAYS-1:0]             free_oh;
   logic                        full;
   logic [WAYS-1:0]             new_valid;
   logic [WAYS-1:0][KEY_W-1:0]  new_keys;
   logic                        modify;
   logic [2:0]                  res_status;
   logic                        commit;
   logic                        mem_we;
   logic [BKT_W-1:0]            mem_waddr;
   logic [ROW_W-1:0]            mem_wdata;

   assign rd_valid = rd_row_ff[WAYS-1:0];
   assign rd_keys  = rd_row_ff[ROW_W-1:WAYS];

   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         hit[w] = rd_valid[w] && (rd_keys[w] == $unsigned(lk_req_ff.key));
      end
   end

   assign hit_oh  = hit & (~hit + WAYS'(1));
   assign free_oh = ~rd_valid & (rd_valid + WAYS'(1));
   assign full    = &rd_valid;

   always_comb begin
      new_valid  = rd_valid;
      new_keys   = rd_keys;
      modify     = 1'b0;
      count_in   = count_ff;
      res_status = ST_NOT_FOUND;
      case (lk_req_ff.req_type)
         REQ_INSERT: begin
            if (|hit) begin
               res_status = ST_PRESENT;
            end else if (full) begin
               res_status = ST_FULL;
            end else begin
               modify     = 1'b1;
               new_valid  = rd_valid | free_oh;
               for (int w = 0; w < WAYS; w++) begin
                  if (free_oh[w]) begin
                     new_keys[w] = $unsigned(lk_req_ff.key);
                  end
               end
               count_in   = count_ff + COUNT_W'(1);
               res_status = ST_INSERTED;
            end
         end
         REQ_REMOVE: begin
            if (|hit) begin
               modify     = 1'b1;
               new_valid  = rd_valid & ~hit_oh;
               count_in   = count_ff - COUNT_W'(1);
               res_status = ST_REMOVED;
            end
         end
         default: begin
            res_status = (|hit) ? ST_FOUND : ST_NOT_FOUND;
         end
      endcase
   end

   assign commit    = lk_valid_ff && res_ready;
   assign mem_we    = clr_active_ff || (commit && modify);
   assign mem_waddr = clr_active_ff ? clr_idx_ff : lk_bucket_ff;
   assign mem_wdata = clr_active_ff ? '0 : {new_keys, new_valid};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         row_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (take) begin
         rd_row_ff <= row_mem_ff[take_bucket];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_idx_ff    <= '0;
         lk_valid_ff   <= 1'b0;
         count_ff      <= '0;
      end else begin
         if (clr_active_ff) begin
            if (clr_idx_ff == BKT_W'(NUM_BUCKETS - 1)) begin
               clr_active_ff <= 1'b0;
            end
            clr_idx_ff <= clr_idx_ff + BKT_W'(1);
         end
         if (take) begin
            lk_valid_ff <= 1'b1;
         end else if (commit) begin
            lk_valid_ff <= 1'b0;
         end
         if (commit) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         lk_req_ff    <= take_req;
         lk_bucket_ff <= take_bucket;
      end
   end

   assign status.ready    = !clr_active_ff && !lk_valid_ff;
   assign status.clearing = clr_active_ff;

   assign res_valid              = lk_valid_ff;
   assign res_data.status        = res_status;
   assign res_data.element_count = count_in;

endmodule

/* design/hash_set_engine.sv */
// Hash set engine: keeps a set of 32-bit keys in NUM_BUCKETS buckets of
// WAYS_PER_BUCKET ways each, and answers one request (insert, query or
// remove) with one response carrying a status and the element count after
// the request. The bucket is the key's bit pattern, taken as unsigned,
// modulo NUM_BUCKETS; it is worked out in a three-stage pipeline that
// multiplies by a reciprocal and corrects once. The table itself is a single
// synchronous memory holding one row per bucket, so each request costs one
// row read and then a compare-and-write-back step, and the table takes no
// new request until the last one is written back. A request passes the
// three hash stages, the table's lookup register and the output register.
// Since the next read never starts before the previous write has landed,
// requests to the same bucket follow each other safely. After reset the
// block clears the occupied bits of every row, one row after another, and
// stalls requests until that is done. A response waiting in the output
// register holds the table, and the hash pipeline, which only moves as a
// whole, stops taking requests as soon as a request waits in its last
// stage for the table.
module hash_set_engine import hse_pkg::*; #(
   parameter int unsigned NUM_BUCKETS     = NUM_BUCKETS_DEF,
   parameter int unsigned WAYS_PER_BUCKET = WAYS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   localparam int unsigned BKT_W = $clog2(NUM_BUCKETS);
   localparam int unsigned TOTAL = NUM_BUCKETS * WAYS_PER_BUCKET;

   logic             h_valid;
   req_payload_type  h_req;
   logic [BKT_W-1:0] h_bucket;
   logic             advance;
   logic             req_accept;
   logic             take;

   tbl_status_type   tbl_status;
   logic             tbl_res_valid;
   rsp_payload_type  tbl_res_data;
   logic             out_free;

   logic             rsp_valid_ff;
   rsp_payload_type  rsp_data_ff;

   // The hash pipeline moves as a whole whenever its last stage is empty or
   // is handed to the table in this cycle.
   assign take       = h_valid && tbl_status.ready;
   assign advance    = !h_valid || take;
   assign req_stall  = tbl_status.clearing || !advance;
   assign req_accept = req_valid && !req_stall;

   hse_hash #(
      .NUM_BUCKETS (NUM_BUCKETS)
   ) u_hash (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_accept),
      .in_req     (req_data),
      .advance    (advance),
      .out_valid  (h_valid),
      .out_req    (h_req),
      .out_bucket (h_bucket)
   );

   hse_table #(
      .NUM_BUCKETS     (NUM_BUCKETS),
      .WAYS_PER_BUCKET (WAYS_PER_BUCKET)
   ) u_table (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .take_req    (h_req),
      .take_bucket (h_bucket),
      .status      (tbl_status),
      .res_valid   (tbl_res_valid),
      .res_ready   (out_free),
      .res_data    (tbl_res_data)
   );

   // The output register takes a fresh response whenever it is empty or its
   // current response leaves in this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= tbl_res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && tbl_res_valid) begin
         rsp_data_ff <= tbl_res_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The reduced key always names an existing bucket.
   a_bucket_range : assert property (@(posedge clock) disable iff (reset)
      h_valid |-> (32'(h_bucket) < NUM_BUCKETS))
      else $error("bucket index beyond the table");

   // A request waiting at the end of the hash pipeline keeps its bucket.
   a_bucket_hold : assert property (@(posedge clock) disable iff (reset)
      (h_valid && !advance) |=> (h_valid && $stable(h_bucket)))
      else $error("bucket changed while waiting for the table");

   // While the table is being cleared no response can appear.
   a_clear_quiet : assert property (@(posedge clock) disable iff (reset)
      tbl_status.clearing |-> (!tbl_res_valid && !rsp_valid_ff))
      else $error("response during the clearing pass");

   // With up to 1023 ways, the element count stays within their number.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((TOTAL > 1023) || (32'(rsp_data_ff.element_count) <= TOTAL)))
      else $error("element count beyond table capacity");

endmodule
